@@ sv/bitmap_id_allocator_defines.svh @@
// Assertion macros for the bitmap id allocator checker.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bia_pkg.sv @@
// Types, codes and constants of the bitmap id allocator.
package bia_pkg;

  localparam int MAP_WORDS_DEF = 32;
  localparam int BITS_PER_WORD = 8;
  localparam int BIT_W         = 3;
  localparam int ID_W          = 9;
  localparam int ST_W          = 2;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     found;
    logic [BIT_W-1:0]         bit_idx;
    logic [BITS_PER_WORD-1:0] set_word;
  } ffz_res_t;

endpackage

@@ sv/bia_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bia_ffz.sv @@
// Find-first-zero unit: lowest clear bit of one bitmap word and the word with it set.
module bia_ffz
  import bia_pkg::*;
(
  input  logic [BITS_PER_WORD-1:0] word,
  output ffz_res_t                 res
);

  always_comb begin
    res.found   = 1'b0;
    res.bit_idx = '0;
    // walk from the top down so the lowest clear bit wins
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found   = 1'b1;
        res.bit_idx = BIT_W'(i);
      end
    end
    res.set_word = word | (BITS_PER_WORD'(1) << res.bit_idx);
  end

endmodule

@@ sv/bitmap_id_allocator.sv @@
// Top level of the bitmap id allocator: sequencer, bitmap RAM and find-first-zero unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in_     | input     | in_valid / in_ready  | in_req_type, in_release_id
//   out_    | output    | out_valid / out_ready| out_granted_id, out_status
//
// Allocate: accept in S_IDLE, then one bitmap word per cycle through the
// find-first-zero unit in S_SCAN, then post the item from S_DONE.
// Release: accept, read-modify-write in S_REL, post; an ignored release skips S_REL.
// After reset a clearing pass writes zero to all MAP_WORDS words, one per cycle,
// with in_ready low. A finished item waits in the output register while the
// next item is accepted; the sequencer holds in S_DONE while it is full, out_ready low.
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_req_type,
  input  logic [ID_W-1:0] in_release_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_granted_id,
  output logic [ST_W-1:0] out_status
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int EW = (AW + BIT_W + 1 > ID_W + 1) ? AW + BIT_W + 1 : ID_W + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [EW-1:0] CAPACITY  = EW'(MAP_WORDS * BITS_PER_WORD);

  state_t state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [BIT_W-1:0] rel_bit_r, rel_bit_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  status_t          res_st_r, res_st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r;
  status_t          out_st_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [BITS_PER_WORD-1:0] ram_wdata, ram_rdata;
  ffz_res_t                 ffz;
  logic                     load_out;

  logic [EW-1:0]    rel_ext, rel_slot, grant_full;
  logic             rel_ok;
  logic [AW-1:0]    rel_word;
  logic [BIT_W-1:0] rel_bit;

  assign rel_ext    = EW'(in_release_id);
  assign rel_ok     = (rel_ext != '0) && (rel_ext <= CAPACITY);
  assign rel_slot   = rel_ext - EW'(1);
  assign rel_word   = rel_slot[AW+BIT_W-1:BIT_W];
  assign rel_bit    = rel_slot[BIT_W-1:0];
  assign grant_full = EW'({ptr_r, ffz.bit_idx}) + EW'(1);

  bia_ram #(
    .WIDTH(BITS_PER_WORD),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bia_ffz u_ffz (
    .word(ram_rdata),
    .res (ffz)
  );

  // next state and datapath registers
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    rel_bit_nxt = rel_bit_r;
    res_id_nxt  = res_id_r;
    res_st_nxt  = res_st_r;
    unique case (state_r)
      S_CLEAR: begin
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_WORD) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_ALLOC) begin
            ptr_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (rel_ok) begin
            ptr_nxt     = rel_word;
            rel_bit_nxt = rel_bit;
            state_nxt   = S_REL;
          end else begin
            res_id_nxt = '0;
            res_st_nxt = ST_IGNORED;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SCAN: begin
        priority if (ffz.found) begin
          res_id_nxt = grant_full[ID_W-1:0];
          res_st_nxt = ST_ALLOCATED;
          state_nxt  = S_DONE;
        end else if (ptr_r == LAST_WORD) begin
          res_id_nxt = '0;
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_REL: begin
        res_id_nxt = '0;
        res_st_nxt = ST_RELEASED;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM port and handshake controls
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    ram_raddr = ptr_r + AW'(1);
    load_out  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = (in_req_type == REQ_RELEASE) ? rel_word : '0;
      end
      S_SCAN: begin
        ram_we    = ffz.found;
        ram_wdata = ffz.set_word;
      end
      S_REL: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(BITS_PER_WORD'(1) << rel_bit_r);
      end
      S_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_bit_r <= rel_bit_nxt;
    res_id_r  <= res_id_nxt;
    res_st_r  <= res_st_nxt;
    if (load_out) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_id_r;
  assign out_status     = out_st_r;

endmodule

@@ sv/bia_checker.sv @@
// Port-level checker for the bitmap id allocator, bound to the top level.
`include "bitmap_id_allocator_defines.svh"

module bia_checker
  import bia_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_granted_id,
  input logic [ST_W-1:0] out_status
);

  // a stalled result holds
  `BIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_granted_id) && $stable(out_status), "stalled result changed")

  // a grant always carries a real id
  `BIA_ASSERT_NOW(a_grant_nonzero, out_valid && (out_status == ST_ALLOCATED), out_granted_id != '0, "allocated status with id zero")

  // every other outcome carries id zero
  `BIA_ASSERT_NOW(a_other_zero, out_valid && (out_status != ST_ALLOCATED), out_granted_id == '0, "non-grant result with nonzero id")

  // one item at a time: busy right after an accept
  `BIA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after accept")

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);
